// ===== rtl/core/jfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jfp_pkg;

  localparam int JFP_MAX_COLUMNS   = 1024;
  localparam int JFP_MAX_ROWS      = 1024;
  localparam int JFP_FRACTION_BITS = 24;
  localparam int JFP_SIZE_W        = 11;
  localparam int JFP_CFG_AW        = 2;

  typedef enum logic [JFP_CFG_AW-1:0] {
    REG_COLUMNS   = 2'd0,
    REG_ROWS      = 2'd1,
    REG_THRESHOLD = 2'd2
  } jfp_reg_t;

  // bus width rounded up to whole bytes
  function automatic int jfp_pad8(input int w);
    return ((w + 7) / 8) * 8;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/jacobi_five_point_stencil_sweep.sv =====
// Jacobi sweep, five-point stencil, over a grid streamed in raster order.
// Input: one old grid cell per request (halo included) on in_tdata; rows of
// interior_columns + 2 cells, interior_rows + 2 rows per sweep.
// Output: one request per interior cell, in raster order: the mean of its four
// neighbors, the running maximum change of the sweep, out_tlast on the last
// interior cell and out_tuser (converged) beside it. Halo-completing cells
// give no output.
// Configuration: cfg_we / cfg_addr / cfg_wdata, written between sweeps or while idle.
// Throughput: one cell per cycle while the output is not stalled, set by the
// single-port read of each line buffer, prefetched ahead of the cell that uses it.
// Pipeline: a completed cell's result passes the p1, p2 and output registers.
// Reset: positions, window and running maximum clear; sizes go to their
// maxima, threshold to 0.001. Line buffers are not cleared.
// Stall: a held out_tready freezes the output register; the two inner stages
// keep filling, then in_tready drops until the output is taken.
`timescale 1ns / 1ps
`default_nettype none

module jacobi_five_point_stencil_sweep
  import jfp_pkg::*;
#(
  parameter int MAX_COLUMNS   = JFP_MAX_COLUMNS,
  parameter int MAX_ROWS      = JFP_MAX_ROWS,
  parameter int FRACTION_BITS = JFP_FRACTION_BITS,
  localparam int VAL_W = FRACTION_BITS + 1,
  localparam int IN_W  = jfp_pad8(VAL_W),
  localparam int OUT_W = jfp_pad8(2 * VAL_W),
  localparam int CFG_W = (VAL_W > JFP_SIZE_W) ? VAL_W : JFP_SIZE_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_W-1:0]       in_tdata,   // cell_value
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_W-1:0]      out_tdata,  // new_value, running_max_change
  output logic                       out_tlast,  // last_cell
  output logic                       out_tuser,  // converged
  input  wire logic                  cfg_we,
  input  wire logic [JFP_CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  localparam int LINE_D = MAX_COLUMNS + 2;
  localparam int COL_W  = $clog2(LINE_D);
  localparam int ROW_W  = $clog2(MAX_ROWS + 2);
  localparam int CC_W   = ($clog2(MAX_COLUMNS + 1) > JFP_SIZE_W) ?
                          $clog2(MAX_COLUMNS + 1) : JFP_SIZE_W;
  localparam int RC_W   = ($clog2(MAX_ROWS + 1) > JFP_SIZE_W) ?
                          $clog2(MAX_ROWS + 1) : JFP_SIZE_W;
  localparam logic [VAL_W-1:0] THR_RST =
    VAL_W'(((64'd1 << FRACTION_BITS) + 64'd500) / 64'd1000);

  typedef struct packed {
    logic res;
    logic last;
    logic swe;
  } flags_t;

  // configuration
  logic [CC_W-1:0]  cols_r;
  logic [RC_W-1:0]  rows_r;
  logic [VAL_W-1:0] thr_r;

  // position
  logic [COL_W-1:0] c_r, c_nxt, last_col, rd_addr;
  logic [ROW_W-1:0] r_r, r_nxt, last_row;
  logic [CC_W-1:0]  cols_cl;
  logic [RC_W-1:0]  rows_cl;
  logic             row_end;
  flags_t           fl;

  // line buffers and window
  logic [VAL_W-1:0]   x, up_rd, mid_rd;
  logic [3*VAL_W-1:0] w0, w1;
  logic [VAL_W-1:0]   w0_top, w0_mid, w0_bot, w1_mid;
  logic [VAL_W+1:0]   sum;

  // pipeline
  logic             p1_v_r, p2_v_r, out_v_r;
  flags_t           p1_fl_r, p2_fl_r;
  logic [VAL_W-1:0] p1_fresh_r, p1_centre_r, p2_fresh_r, p2_diff_r;
  logic [VAL_W-1:0] out_new_r, out_max_r, max_r, max_nxt, diff;
  logic             out_last_r, out_conv_r;
  logic             out_ld, p2_free, p1_mv, in_fire;

  assign x = in_tdata[VAL_W-1:0];

  always_comb begin
    cols_cl = cols_r;
    if (cols_r == '0) begin
      cols_cl = CC_W'(1);
    end else if (cols_r > CC_W'(MAX_COLUMNS)) begin
      cols_cl = CC_W'(MAX_COLUMNS);
    end
    rows_cl = rows_r;
    if (rows_r == '0) begin
      rows_cl = RC_W'(1);
    end else if (rows_r > RC_W'(MAX_ROWS)) begin
      rows_cl = RC_W'(MAX_ROWS);
    end
    last_col = COL_W'(cols_cl) + COL_W'(1);
    last_row = ROW_W'(rows_cl) + ROW_W'(1);

    row_end  = (c_r >= last_col);
    fl.res   = (r_r >= ROW_W'(2)) && (c_r >= COL_W'(2)) &&
               (r_r <= last_row) && (c_r <= last_col);
    fl.last  = (r_r == last_row) && (c_r == last_col);
    fl.swe   = row_end && (r_r >= last_row);

    c_nxt = row_end ? '0 : c_r + COL_W'(1);
    r_nxt = r_r;
    if (row_end) begin
      r_nxt = fl.swe ? '0 : r_r + ROW_W'(1);
    end
    rd_addr = in_fire ? c_nxt : c_r;
  end

  jfp_line_buf #(.W(VAL_W), .DEPTH(LINE_D)) u_upper (
    .clk   (clk),
    .we    (in_fire),
    .waddr (c_r),
    .wdata (mid_rd),
    .raddr (rd_addr),
    .rdata (up_rd)
  );

  jfp_line_buf #(.W(VAL_W), .DEPTH(LINE_D)) u_middle (
    .clk   (clk),
    .we    (in_fire),
    .waddr (c_r),
    .wdata (x),
    .raddr (rd_addr),
    .rdata (mid_rd)
  );

  jfp_win_cell #(.W(VAL_W)) u_cell0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (in_fire),
    .col_in  ({x, mid_rd, up_rd}),
    .col_out (w0)
  );

  jfp_win_cell #(.W(VAL_W)) u_cell1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (in_fire),
    .col_in  (w0),
    .col_out (w1)
  );

  assign w0_top = w0[VAL_W-1:0];
  assign w0_mid = w0[2*VAL_W-1:VAL_W];
  assign w0_bot = w0[3*VAL_W-1:2*VAL_W];
  assign w1_mid = w1[2*VAL_W-1:VAL_W];
  assign sum    = (VAL_W+2)'(w0_top) + (VAL_W+2)'(w0_bot) +
                  (VAL_W+2)'(w1_mid) + (VAL_W+2)'(mid_rd);

  // handshake across stages
  assign out_ld    = p2_v_r && (!out_v_r || out_tready);
  assign p2_free   = !p2_v_r || out_ld;
  assign p1_mv     = p1_v_r && p2_free;
  assign in_tready = !p1_v_r || p2_free;
  assign in_fire   = in_tvalid && in_tready;

  assign diff = (p1_fresh_r >= p1_centre_r) ? p1_fresh_r - p1_centre_r
                                            : p1_centre_r - p1_fresh_r;

  always_comb begin
    max_nxt = max_r;
    if (p2_fl_r.res && (p2_diff_r > max_r)) begin
      max_nxt = p2_diff_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= CC_W'(MAX_COLUMNS);
      rows_r  <= RC_W'(MAX_ROWS);
      thr_r   <= THR_RST;
      c_r     <= '0;
      r_r     <= '0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      max_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (jfp_reg_t'(cfg_addr))
          REG_COLUMNS:   cols_r <= CC_W'(cfg_wdata[JFP_SIZE_W-1:0]);
          REG_ROWS:      rows_r <= RC_W'(cfg_wdata[JFP_SIZE_W-1:0]);
          REG_THRESHOLD: thr_r  <= cfg_wdata[VAL_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        c_r <= c_nxt;
        r_r <= r_nxt;
      end
      if (in_fire) begin
        p1_v_r <= fl.res || fl.swe;
      end else if (p1_mv) begin
        p1_v_r <= 1'b0;
      end
      if (p1_mv) begin
        p2_v_r <= 1'b1;
      end else if (out_ld) begin
        p2_v_r <= 1'b0;
      end
      if (out_ld) begin
        out_v_r <= p2_fl_r.res;
        max_r   <= p2_fl_r.swe ? '0 : max_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1_fl_r     <= fl;
      p1_fresh_r  <= sum[VAL_W+1:2];
      p1_centre_r <= w0_mid;
    end
    if (p1_mv) begin
      p2_fl_r    <= p1_fl_r;
      p2_fresh_r <= p1_fresh_r;
      p2_diff_r  <= diff;
    end
    if (out_ld) begin
      out_new_r  <= p2_fresh_r;
      out_max_r  <= max_nxt;
      out_last_r <= p2_fl_r.last;
      out_conv_r <= p2_fl_r.last && (max_nxt < thr_r);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'({out_max_r, out_new_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_conv_r;

endmodule

`default_nettype wire

// ===== rtl/core/jfp_line_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jfp_line_buf #(
  parameter int W     = 25,
  parameter int DEPTH = 1026,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/jfp_win_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// one window column: {bottom, middle, top}
module jfp_win_cell #(
  parameter int W = 25
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic [3*W-1:0] col_in,
  output logic      [3*W-1:0] col_out
);

  logic [3*W-1:0] col_r;
  logic [3*W-1:0] col_nxt;

  always_comb begin
    col_nxt = en ? col_in : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule

`default_nettype wire

// ===== rtl/core/jfp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jfp_checker
  import jfp_pkg::*;
#(
  parameter int FRACTION_BITS = JFP_FRACTION_BITS,
  localparam int VAL_W = FRACTION_BITS + 1,
  localparam int OUT_W = jfp_pad8(2 * VAL_W)
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata,
  input wire logic             out_tlast,
  input wire logic             out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("output request changed while stalled");

  a_conv_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("converged flag outside the last cell");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a held result");

endmodule

bind jacobi_five_point_stencil_sweep jfp_checker #(
  .FRACTION_BITS (FRACTION_BITS)
) u_jfp_checker (.*);

`default_nettype wire

// ===== tb/tb_jacobi_five_point_stencil_sweep.sv =====
`timescale 1ns / 1ps

module tb_jacobi_five_point_stencil_sweep;
  import jfp_pkg::*;

  localparam int VAL_W       = JFP_FRACTION_BITS + 1;
  localparam int IN_W        = ((VAL_W + 7) / 8) * 8;
  localparam int OUT_W       = ((2 * VAL_W + 7) / 8) * 8;
  localparam int CFG_W       = (VAL_W > JFP_SIZE_W) ? VAL_W : JFP_SIZE_W;
  localparam int LINE_DEPTH  = JFP_MAX_COLUMNS + 2;
  localparam logic [VAL_W-1:0] MAXV     = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] ONE_FP   = VAL_W'(1 << JFP_FRACTION_BITS);
  localparam logic [VAL_W-1:0] THR_INIT =
    VAL_W'(((1 << JFP_FRACTION_BITS) + 500) / 1000);
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int RANDOM_CELLS  = 300;

  typedef enum logic [1:0] {OP_CELL, OP_CFG, OP_SETTLE, OP_HOLD} feed_op_t;
  typedef enum logic [2:0] {
    STYLE_FULL, STYLE_RANGE, STYLE_NEAR, STYLE_FLAT, STYLE_EDGE
  } cell_style_t;

  typedef struct packed {
    feed_op_t         op;
    jfp_reg_t         addr;
    logic [VAL_W-1:0] value;
  } feed_cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] new_value;
    logic [VAL_W-1:0] peak;
    logic             last;
    logic             conv;
  } sweep_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;   // cell_value
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;       // new_value, running_max_change
  logic                  out_tlast;       // last_cell
  logic                  out_tuser;       // converged
  logic                  cfg_we = 1'b0;
  logic [JFP_CFG_AW-1:0] cfg_addr = REG_COLUMNS;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  jacobi_five_point_stencil_sweep u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // grid predictor state
  logic [VAL_W-1:0] upper_ln [LINE_DEPTH];
  logic [VAL_W-1:0] middle_ln [LINE_DEPTH];
  logic [VAL_W-1:0] win [6];
  int unsigned      row_at = 0;
  int unsigned      col_at = 0;
  logic [VAL_W-1:0] peak_change = '0;
  logic [10:0]      cols_reg = 11'(JFP_MAX_COLUMNS);
  logic [10:0]      rows_reg = 11'(JFP_MAX_ROWS);
  logic [VAL_W-1:0] thr_reg = THR_INIT;

  sweep_result_t pending_results[$];
  feed_cmd_t     feed_q[$];
  int            mismatches = 0;
  longint        cycles = 0;
  longint        cycle_limit = 0;

  // stimulus-side position tracking, keeps config changes legal
  logic [10:0]   gen_cols = 11'(JFP_MAX_COLUMNS);
  logic [10:0]   gen_rows = 11'(JFP_MAX_ROWS);
  int unsigned   gen_r = 0;
  int unsigned   gen_c = 0;
  int            cells_fed = 0;

  logic          in_took = 1'b0;
  logic          out_took = 1'b0;
  int            gap_left = 0;
  int            settle_left = SETTLE_CYCLES;
  int            drv_run = 0;
  bit            drv_quiet = 1'b0;
  int            hold_reqs = 0;
  int            hold_seen = 0;
  int            hold_left = 0;
  int            stall_left = 0;
  int            rx_run = 0;
  bit            rx_quiet = 1'b0;

  initial begin
    for (int i = 0; i < LINE_DEPTH; i++) begin
      upper_ln[i] = '0;
      middle_ln[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
  end

  function automatic int unsigned eff_size(input logic [10:0] v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int p;
    if (quiet) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report(input string what, input logic [VAL_W-1:0] got,
                        input logic [VAL_W-1:0] want);
    if (mismatches < 200)
      $display("ERROR %s: got %h, want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic apply_cfg(input jfp_reg_t idx, input logic [CFG_W-1:0] v);
    case (idx)
      REG_COLUMNS:   cols_reg = v[10:0];
      REG_ROWS:      rows_reg = v[10:0];
      REG_THRESHOLD: thr_reg = v[VAL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic stencil_step(input logic [VAL_W-1:0] x);
    int unsigned      last_c, last_r, slot;
    logic [VAL_W-1:0] top, mid, fresh, diff;
    logic [VAL_W+1:0] sum;
    sweep_result_t    res;
    last_c = eff_size(cols_reg, JFP_MAX_COLUMNS) + 1;
    last_r = eff_size(rows_reg, JFP_MAX_ROWS) + 1;
    slot = (col_at < LINE_DEPTH) ? col_at : LINE_DEPTH - 1;
    top = upper_ln[slot];
    mid = middle_ln[slot];
    if (row_at >= 2 && col_at >= 2 && row_at <= last_r && col_at <= last_c) begin
      sum = (VAL_W+2)'(win[0]) + (VAL_W+2)'(win[2]) + (VAL_W+2)'(win[4]) + (VAL_W+2)'(mid);
      fresh = sum[VAL_W+1:2];
      diff = (fresh >= win[1]) ? fresh - win[1] : win[1] - fresh;
      if (diff > peak_change) peak_change = diff;
      res.new_value = fresh;
      res.peak = peak_change;
      res.last = (row_at == last_r) && (col_at == last_c);
      res.conv = res.last && (peak_change < thr_reg);
      pending_results.push_back(res);
    end
    upper_ln[slot] = mid;
    middle_ln[slot] = x;
    win[3] = win[0];
    win[4] = win[1];
    win[5] = win[2];
    win[0] = top;
    win[1] = mid;
    win[2] = x;
    if (col_at >= last_c) begin
      col_at = 0;
      if (row_at >= last_r) begin
        row_at = 0;
        peak_change = '0;
      end else begin
        row_at++;
      end
    end else begin
      col_at++;
    end
  endtask

  // stimulus building
  task automatic add_cmd(input feed_op_t op, input jfp_reg_t addr, input logic [VAL_W-1:0] v);
    feed_cmd_t cmd;
    cmd.op = op;
    cmd.addr = addr;
    cmd.value = v;
    feed_q.push_back(cmd);
  endtask

  task automatic add_settle_cmd();
    add_cmd(OP_SETTLE, REG_COLUMNS, '0);
  endtask

  task automatic add_cell(input logic [VAL_W-1:0] v);
    add_cmd(OP_CELL, REG_COLUMNS, v);
    cells_fed++;
    if (gen_c >= eff_size(gen_cols, JFP_MAX_COLUMNS) + 1) begin
      gen_c = 0;
      if (gen_r >= eff_size(gen_rows, JFP_MAX_ROWS) + 1) gen_r = 0;
      else gen_r++;
    end else begin
      gen_c++;
    end
  endtask

  task automatic add_cfg(input jfp_reg_t idx, input int unsigned v);
    add_cmd(OP_CFG, idx, VAL_W'(v));
    if (idx == REG_COLUMNS) gen_cols = v[10:0];
    if (idx == REG_ROWS) gen_rows = v[10:0];
  endtask

  function automatic logic [VAL_W-1:0] make_cell(input cell_style_t s,
                                                 input logic [VAL_W-1:0] base);
    int p;
    case (s)
      STYLE_FULL:  return VAL_W'($urandom);
      STYLE_RANGE: return VAL_W'($urandom_range(0, ONE_FP));
      STYLE_NEAR:  return base + VAL_W'($urandom_range(0, 7));
      STYLE_FLAT:  return base;
      default: begin
        p = $urandom_range(2);
        if (p == 0) return '0;
        if (p == 1) return ONE_FP;
        return MAXV;
      end
    endcase
  endfunction

  task automatic finish_sweep(input cell_style_t s, input logic [VAL_W-1:0] base);
    do add_cell(make_cell(s, base));
    while (gen_r != 0 || gen_c != 0);
  endtask

  function automatic logic [VAL_W-1:0] pick_size();
    int p;
    p = $urandom_range(99);
    if (p < 70) return VAL_W'($urandom_range(1, 6));
    if (p < 90) return VAL_W'($urandom_range(7, 20));
    return VAL_W'($urandom_range(0, 40));
  endfunction

  function automatic logic [VAL_W-1:0] pick_threshold();
    case ($urandom_range(6))
      0: return '0;
      1: return VAL_W'($urandom_range(0, 8));
      2: return VAL_W'($urandom_range(0, 1 << 20));
      3: return VAL_W'($urandom);
      4: return ONE_FP;
      5: return MAXV;
      default: return THR_INIT;
    endcase
  endfunction

  // sender
  always @(negedge clk) begin
    logic      nv;
    logic      nwe;
    feed_cmd_t cmd;
    nv = in_tvalid && !in_took;
    nwe = 1'b0;
    if (rst_n && !nv) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (feed_q.size() != 0) begin
        cmd = feed_q[0];
        case (cmd.op)
          OP_CELL: begin
            nv = 1'b1;
            in_tdata <= IN_W'(cmd.value);
            void'(feed_q.pop_front());
            if (drv_run == 0) begin
              drv_quiet = ($urandom_range(3) == 0);
              drv_run = $urandom_range(20, 150);
            end
            drv_run--;
            gap_left = pick_gap(drv_quiet);
          end
          OP_CFG: begin
            nwe = 1'b1;
            cfg_addr <= cmd.addr;
            cfg_wdata <= CFG_W'(cmd.value);
            void'(feed_q.pop_front());
          end
          OP_SETTLE: begin
            if (pending_results.size() != 0) begin
              settle_left = SETTLE_CYCLES;
            end else if (settle_left != 0) begin
              settle_left--;
            end else begin
              settle_left = SETTLE_CYCLES;
              void'(feed_q.pop_front());
            end
          end
          default: begin
            hold_reqs <= hold_reqs + 1;
            void'(feed_q.pop_front());
          end
        endcase
      end
    end
    in_tvalid <= nv;
    cfg_we <= nwe;
  end

  // receiver
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (out_took) begin
        if (rx_run == 0) begin
          rx_quiet = ($urandom_range(3) == 0);
          rx_run = $urandom_range(20, 150);
        end
        rx_run--;
        stall_left = pick_gap(rx_quiet);
      end
      if (hold_left != 0) hold_left--;
      else if (stall_left != 0) stall_left--;
      else rdy = 1'b1;
    end
    out_tready <= rdy;
  end

  // prediction and checking
  always @(posedge clk) begin
    sweep_result_t got, want;
    cycles++;
    if (cycles > cycle_limit) begin
      $display("Mismatches found");
      $finish;
    end
    in_took <= rst_n && in_tvalid && in_tready;
    out_took <= rst_n && out_tvalid && out_tready;
    if (rst_n && cfg_we) apply_cfg(jfp_reg_t'(cfg_addr), cfg_wdata);
    if (rst_n && in_tvalid && in_tready) stencil_step(in_tdata[VAL_W-1:0]);
    if (rst_n && out_tvalid && out_tready) begin
      got.new_value = out_tdata[VAL_W-1:0];
      got.peak = out_tdata[2*VAL_W-1:VAL_W];
      got.last = out_tlast;
      got.conv = out_tuser;
      if (pending_results.size() == 0) begin
        report("unexpected result, new_value", got.new_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.new_value !== want.new_value)
          report("new_value", got.new_value, want.new_value);
        if (got.peak !== want.peak)
          report("running_max_change", got.peak, want.peak);
        if (got.last !== want.last)
          report("last_cell", VAL_W'(got.last), VAL_W'(want.last));
        if (got.conv !== want.conv)
          report("converged", VAL_W'(got.conv), VAL_W'(want.conv));
      end
    end
  end

  initial begin
    cell_style_t      style;
    logic [VAL_W-1:0] base;
    int               rand_start, sweeps, kind, total, n;

    // extremes: mixed 0 / 1.0 / all-ones, then an all-ones grid that
    // overflows 25 bits in the 27-bit sum and converges under the reset threshold
    add_cfg(REG_COLUMNS, 3);
    add_cfg(REG_ROWS, 2);
    finish_sweep(STYLE_EDGE, '0);
    add_settle_cmd();
    add_cfg(REG_COLUMNS, 1);
    add_cfg(REG_ROWS, 1);
    finish_sweep(STYLE_FLAT, MAXV);

    // size changed mid-sweep: row and sweep end exactly at the new limits
    add_settle_cmd();
    add_cfg(REG_COLUMNS, 4);
    add_cfg(REG_ROWS, 4);
    add_cfg(REG_THRESHOLD, MAXV);
    repeat (21) add_cell(make_cell(STYLE_FULL, '0));
    add_settle_cmd();
    add_cfg(REG_COLUMNS, 2);
    add_cfg(REG_ROWS, 2);
    finish_sweep(STYLE_FULL, '0);

    // column already beyond the new row end
    add_settle_cmd();
    add_cfg(REG_COLUMNS, 4);
    add_cfg(REG_ROWS, 3);
    repeat (17) add_cell(make_cell(STYLE_RANGE, '0));
    add_settle_cmd();
    add_cfg(REG_COLUMNS, 1);
    finish_sweep(STYLE_RANGE, '0);

    // column count above the maximum acts as the maximum, zero rows as one:
    // one full-width row, then the rest of the sweep at the smallest width
    add_settle_cmd();
    add_cfg(REG_COLUMNS, 2047);
    add_cfg(REG_ROWS, 0);
    add_cfg(REG_THRESHOLD, 5);
    base = VAL_W'($urandom_range(0, MAXV - 7));
    repeat (JFP_MAX_COLUMNS + 2) add_cell(make_cell(STYLE_NEAR, base));
    add_settle_cmd();
    add_cfg(REG_COLUMNS, 1);
    finish_sweep(STYLE_NEAR, base);

    rand_start = cells_fed;
    sweeps = 0;
    while (cells_fed - rand_start < RANDOM_CELLS) begin
      add_settle_cmd();
      if ($urandom_range(3) != 0) add_cfg(REG_COLUMNS, pick_size());
      if ($urandom_range(3) != 0) add_cfg(REG_ROWS, pick_size());
      if ($urandom_range(2) != 0) add_cfg(REG_THRESHOLD, pick_threshold());
      if (sweeps == 0) begin
        add_cfg(REG_COLUMNS, 12);
        add_cfg(REG_ROWS, 3);
        add_cmd(OP_HOLD, REG_COLUMNS, '0);
      end
      style = cell_style_t'($urandom_range(4));
      base = (style == STYLE_NEAR) ? VAL_W'($urandom_range(0, MAXV - 7)) : VAL_W'($urandom);
      kind = $urandom_range(99);
      if (kind >= 70) begin
        total = (eff_size(gen_cols, JFP_MAX_COLUMNS) + 2) *
                (eff_size(gen_rows, JFP_MAX_ROWS) + 2);
        n = $urandom_range(1, total - 1);
        repeat (n) add_cell(make_cell(style, base));
        add_settle_cmd();
        if (kind >= 85) begin
          // columns may only shrink mid-sweep
          add_cfg(REG_COLUMNS,
                  VAL_W'($urandom_range(0, eff_size(gen_cols, JFP_MAX_COLUMNS))));
          add_cfg(REG_ROWS, pick_size());
        end
      end
      finish_sweep(style, base);
      sweeps++;
    end

    cycle_limit = 400 * longint'(feed_q.size()) + 100000;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    while (feed_q.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
